// ----- design/sbct_pkg.sv -----
// Shared widths, codes and types of the seek budget compaction trigger.
package sbct_pkg;

    localparam int FILE_SLOTS_DEF = 256;
    localparam int TAG_BITS_DEF   = 16;

    localparam int SLOT_W   = 8;
    localparam int LEVEL_W  = 3;
    localparam int SIZE_W   = 40;
    localparam int SHIFT_W  = 5;
    localparam int MINS_W   = 16;
    localparam int BUDGET_W = 32;
    localparam int CMD_W    = 2;
    localparam int CFG_W    = 16;

    localparam logic [CMD_W-1:0] CMD_CHARGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DROP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RETAIN = 2'd2;

    localparam logic CFG_SEEK_SHIFT = 1'b0;
    localparam logic CFG_MIN_SEEKS  = 1'b1;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET     = 5'd14;
    localparam logic [MINS_W-1:0]  MIN_SEEKS_RESET = 16'd100;

    localparam logic [BUDGET_W-1:0] BUDGET_MAX = 32'h7FFF_FFFF;
    localparam logic [BUDGET_W-1:0] BUDGET_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [BUDGET_W-1:0] budget;
        logic                exhausted;
    } t_charge;

endpackage

// ----- design/sbct_budget_ram.sv -----
// Budget table memory: one write port, one registered read port.
module sbct_budget_ram #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [IDX_W-1:0]              i_waddr,
    input  logic [sbct_pkg::BUDGET_W-1:0] i_wdata,
    input  logic                          i_re,
    input  logic [IDX_W-1:0]              i_raddr,
    output logic [sbct_pkg::BUDGET_W-1:0] o_rdata
);
    import sbct_pkg::*;

    logic [BUDGET_W-1:0] r_mem [DEPTH];
    logic [BUDGET_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sbct_charge_calc.sv -----
// Charge datapath: initial budget from file size, saturating decrement.
module sbct_charge_calc (
    input  logic                          i_entry_valid,
    input  logic [sbct_pkg::BUDGET_W-1:0] i_old_budget,
    input  logic [sbct_pkg::SIZE_W-1:0]   i_file_size,
    input  logic [sbct_pkg::SHIFT_W-1:0]  i_shift,
    input  logic [sbct_pkg::MINS_W-1:0]   i_min_seeks,
    output sbct_pkg::t_charge             o_charge
);
    import sbct_pkg::*;

    logic [SIZE_W-1:0]   shifted;
    logic [SIZE_W-1:0]   floored;
    logic [BUDGET_W-1:0] first_budget;
    logic [BUDGET_W-1:0] start_budget;
    logic [BUDGET_W-1:0] dec_budget;

    always_comb begin
        shifted = i_file_size >> i_shift;
        floored = (shifted < SIZE_W'(i_min_seeks)) ? SIZE_W'(i_min_seeks) : shifted;
        // clamp to the signed maximum
        first_budget = (floored > SIZE_W'(BUDGET_MAX)) ? BUDGET_MAX
                                                       : floored[BUDGET_W-1:0];
        start_budget = i_entry_valid ? i_old_budget : first_budget;
        dec_budget   = (start_budget == BUDGET_MIN) ? start_budget
                                                    : start_budget - BUDGET_W'(1);
        o_charge.budget    = dec_budget;
        o_charge.exhausted = dec_budget[BUDGET_W-1] || (dec_budget == '0);
    end

endmodule

// ----- design/seek_budget_compaction_trigger_top.sv -----
// Seek budget compaction trigger: o_valid rises once an accepted transaction has passed the
// update stage and output registers. Throughput one transaction per cycle while i_ready does
// not hold a result. The budget table read is registered at accept; a same-slot write from
// the item ahead is forwarded into the update stage. A waiting result holds the update
// stage: one more transaction is taken, then o_ready stays low until the result leaves.
// Sync active-low reset clears entry valid bits and record, resets config; no table pass.
module seek_budget_compaction_trigger_top #(
    parameter int FILE_SLOTS = sbct_pkg::FILE_SLOTS_DEF,
    parameter int TAG_BITS   = sbct_pkg::TAG_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [sbct_pkg::CMD_W-1:0]   i_command,
    input  logic [sbct_pkg::SLOT_W-1:0]  i_file_slot,
    input  logic [sbct_pkg::LEVEL_W-1:0] i_file_level,
    input  logic [sbct_pkg::SIZE_W-1:0]  i_file_size,
    input  logic [TAG_BITS-1:0]          i_version_tag,
    input  logic [TAG_BITS-1:0]          i_current_tag,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_fired,
    output logic                         o_record_present,
    output logic [sbct_pkg::LEVEL_W-1:0] o_record_level,
    output logic [sbct_pkg::SLOT_W-1:0]  o_record_slot,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [sbct_pkg::CFG_W-1:0]   i_cfg_data
);
    import sbct_pkg::*;

    // only 8-bit slots are reachable
    localparam int ENTRIES = (FILE_SLOTS < 256) ? FILE_SLOTS : 256;
    localparam int IDX_W   = $clog2(ENTRIES);

    logic [SHIFT_W-1:0] r_shift;
    logic [MINS_W-1:0]  r_min_seeks;

    logic               r_s1_valid;
    logic [CMD_W-1:0]   r_s1_cmd;
    logic [SLOT_W-1:0]  r_s1_slot;
    logic [LEVEL_W-1:0] r_s1_level;
    logic [SIZE_W-1:0]  r_s1_size;
    logic [TAG_BITS-1:0] r_s1_vtag;
    logic [TAG_BITS-1:0] r_s1_ctag;

    logic                r_fwd_hit;
    logic [BUDGET_W-1:0] r_fwd_data;

    logic                r_entry_valid [ENTRIES];

    logic                r_rec_valid;
    logic [LEVEL_W-1:0]  r_rec_level;
    logic [SLOT_W-1:0]   r_rec_slot;
    logic [TAG_BITS-1:0] r_rec_tag;

    logic                r_out_valid;
    logic                r_out_fired;
    logic                r_out_present;
    logic [LEVEL_W-1:0]  r_out_level;
    logic [SLOT_W-1:0]   r_out_slot;

    logic                n_rec_valid;
    logic [LEVEL_W-1:0]  n_rec_level;
    logic [SLOT_W-1:0]   n_rec_slot;
    logic [TAG_BITS-1:0] n_rec_tag;
    logic                n_fired;
    logic                n_present;

    logic                accept;
    logic                s1_adv;
    logic                s1_in_range;
    logic [IDX_W-1:0]    s1_idx;
    logic                s1_entry_valid;
    logic                commit_charge;
    logic                commit_drop;
    logic [BUDGET_W-1:0] ram_rdata;
    logic [BUDGET_W-1:0] old_budget;
    logic                held_for_ctag;
    t_charge             charge;

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign accept  = i_valid && o_ready;

    assign s1_in_range    = int'(r_s1_slot) < FILE_SLOTS;
    assign s1_idx         = IDX_W'(r_s1_slot);
    assign s1_entry_valid = r_entry_valid[s1_idx];
    assign commit_charge  = s1_adv && (r_s1_cmd == CMD_CHARGE) && s1_in_range;
    assign commit_drop    = s1_adv && (r_s1_cmd == CMD_DROP) && s1_in_range;
    assign old_budget     = r_fwd_hit ? r_fwd_data : ram_rdata;

    sbct_budget_ram #(
        .DEPTH (ENTRIES),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (commit_charge),
        .i_waddr (s1_idx),
        .i_wdata (charge.budget),
        .i_re    (accept),
        .i_raddr (IDX_W'(i_file_slot)),
        .o_rdata (ram_rdata)
    );

    sbct_charge_calc u_calc (
        .i_entry_valid (s1_entry_valid),
        .i_old_budget  (old_budget),
        .i_file_size   (r_s1_size),
        .i_shift       (r_shift),
        .i_min_seeks   (r_min_seeks),
        .o_charge      (charge)
    );

    always_comb begin
        held_for_ctag = r_rec_valid && (r_rec_tag == r_s1_ctag);
        n_rec_valid   = r_rec_valid;
        n_rec_level   = r_rec_level;
        n_rec_slot    = r_rec_slot;
        n_rec_tag     = r_rec_tag;
        n_fired       = 1'b0;
        unique case (r_s1_cmd)
            CMD_CHARGE: begin
                if (s1_in_range && charge.exhausted && (r_s1_vtag == r_s1_ctag)
                    && !held_for_ctag) begin
                    n_rec_valid = 1'b1;
                    n_rec_level = r_s1_level;
                    n_rec_slot  = r_s1_slot;
                    n_rec_tag   = r_s1_ctag;
                    n_fired     = 1'b1;
                end
            end
            CMD_RETAIN: begin
                // drop a record left from another version
                if (!held_for_ctag) begin
                    n_rec_valid = 1'b0;
                    n_rec_level = '0;
                    n_rec_slot  = '0;
                    n_rec_tag   = '0;
                end
            end
            default: begin
            end
        endcase
        n_present = n_rec_valid && (n_rec_tag == r_s1_ctag);
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= SHIFT_RESET;
            r_min_seeks <= MIN_SEEKS_RESET;
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_rec_valid <= 1'b0;
            r_rec_level <= '0;
            r_rec_slot  <= '0;
            r_rec_tag   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_entry_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SEEK_SHIFT: r_shift     <= i_cfg_data[SHIFT_W-1:0];
                    CFG_MIN_SEEKS:  r_min_seeks <= i_cfg_data[MINS_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
                // forward the write landing on the same edge as the read
                r_fwd_hit  <= commit_charge && (s1_idx == IDX_W'(i_file_slot));
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (commit_charge) begin
                r_entry_valid[s1_idx] <= 1'b1;
            end else if (commit_drop) begin
                r_entry_valid[s1_idx] <= 1'b0;
            end

            if (s1_adv) begin
                r_rec_valid <= n_rec_valid;
                r_rec_level <= n_rec_level;
                r_rec_slot  <= n_rec_slot;
                r_rec_tag   <= n_rec_tag;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd   <= i_command;
            r_s1_slot  <= i_file_slot;
            r_s1_level <= i_file_level;
            r_s1_size  <= i_file_size;
            r_s1_vtag  <= i_version_tag;
            r_s1_ctag  <= i_current_tag;
            r_fwd_data <= charge.budget;
        end
        if (s1_adv) begin
            r_out_fired   <= n_fired;
            r_out_present <= n_present;
            r_out_level   <= n_present ? n_rec_level : '0;
            r_out_slot    <= n_present ? n_rec_slot : '0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_fired          = r_out_fired;
    assign o_record_present = r_out_present;
    assign o_record_level   = r_out_level;
    assign o_record_slot    = r_out_slot;

    a_fire_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && n_fired) |=> (r_rec_valid && (r_rec_slot == $past(r_s1_slot))))
        else $error("fire did not record the charged slot");

    a_fire_implies_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fired) |-> r_out_present)
        else $error("fired result without a present record");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_present) |-> ((r_out_level == '0) && (r_out_slot == '0)))
        else $error("absent record reports nonzero level or slot");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !o_ready)
        else $error("input accepted while update stage is stalled");

    a_single_fire_per_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && held_for_ctag) |-> !n_fired)
        else $error("second candidate fired for the same tag");

endmodule
